/* hdl/bds_pkg.sv */
// shared types and constants for the 2x2 box downsampler
`timescale 1ns / 1ps

package bds_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;

    // counter and index widths
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int IDX_W        = $clog2(LINE_DEPTH);

    // configuration register widths
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    // width of the saturated frame sizes
    localparam int EW = ($clog2(MAX_WIDTH) + 1 > WIDTH_REG_W) ?
                        $clog2(MAX_WIDTH) + 1 : WIDTH_REG_W;
    localparam int HW = ($clog2(MAX_HEIGHT) + 1 > HEIGHT_REG_W) ?
                        $clog2(MAX_HEIGHT) + 1 : HEIGHT_REG_W;

    // reset values of the size registers
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_last;
    } pixel_out_t;

    // horizontal pair sum of one channel triple
    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } pair_sum_t;

    localparam int PAIR_W = $bits(pair_sum_t);

endpackage

/* hdl/bds_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module bds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/box_downsample_2x2_rgb_core.sv */
// top level of the 2x2 box filter downsampler for rgb pixel streams
`timescale 1ns / 1ps

// one input beat per clock while out keeps up; a result beat appears on out
// after the input beat at an odd row and odd column that closes a 2x2 block,
// once the line store read and the middle stage pass it to the output register
// reset clears counters, held pixel, valids and sets the sizes to 640 x 480;
// the line store is not cleared and needs no sweep, since every entry is written
// on an even row before the odd row reads it

module box_downsample_2x2_rgb_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bds_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  bds_pkg::pixel_in_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output bds_pkg::pixel_out_t                  out_data
);

    // size registers
    logic [bds_pkg::WIDTH_REG_W-1:0]  image_width_reg;
    logic [bds_pkg::HEIGHT_REG_W-1:0] image_height_reg;

    // raster position and the even-column pixel of the current pair
    logic [bds_pkg::COL_W-1:0] column_count_reg, column_count_next;
    logic [bds_pkg::ROW_W-1:0] row_count_reg, row_count_next;
    bds_pkg::pixel_in_t        held_pixel_reg;

    // middle stage: pair sum of the current row waiting for the line store read
    logic                      mid_valid_reg, mid_valid_next;
    bds_pkg::pair_sum_t        mid_pair_reg;
    logic                      mid_last_reg;

    // result register
    logic                      out_valid_reg, out_valid_next;
    bds_pkg::pixel_out_t       out_data_reg;

    // saturated sizes and their even parts
    logic [bds_pkg::EW-1:0] w_eff, w_even, col_ext, col_plus;
    logic [bds_pkg::HW-1:0] h_eff, h_even, row_ext, row_plus;

    logic                      accept;
    logic                      mid_move;
    logic                      in_block;
    logic                      odd_col;
    logic                      odd_row;
    logic                      line_we;
    logic                      produce;
    logic                      last_pixel;
    logic [bds_pkg::IDX_W-1:0] line_idx;
    bds_pkg::pair_sum_t        pair_sum;
    bds_pkg::pair_sum_t        line_rd;
    logic [bds_pkg::PAIR_W-1:0] line_rdata;
    bds_pkg::pixel_out_t       result;
    logic [9:0]                sum_r, sum_g, sum_b;

    // ---------------------------------------------------------------------
    // configuration; the user must write it only while the block is idle (not enforced)
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bds_pkg::WIDTH_RESET;
            image_height_reg <= bds_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bds_pkg::CFG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data[bds_pkg::WIDTH_REG_W-1:0];
                end
                bds_pkg::CFG_IMAGE_HEIGHT:
                begin
                    image_height_reg <= cfg_data[bds_pkg::HEIGHT_REG_W-1:0];
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // sizes saturated to the legal range; a trailing odd column or row
    // falls outside the even part and is dropped
    // ---------------------------------------------------------------------
    always_comb
    begin
        w_eff = bds_pkg::EW'(image_width_reg);
        if (w_eff < bds_pkg::EW'(2))
        begin
            w_eff = bds_pkg::EW'(2);
        end
        else if (w_eff > bds_pkg::EW'(bds_pkg::MAX_WIDTH))
        begin
            w_eff = bds_pkg::EW'(bds_pkg::MAX_WIDTH);
        end

        h_eff = bds_pkg::HW'(image_height_reg);
        if (h_eff < bds_pkg::HW'(2))
        begin
            h_eff = bds_pkg::HW'(2);
        end
        else if (h_eff > bds_pkg::HW'(bds_pkg::MAX_HEIGHT))
        begin
            h_eff = bds_pkg::HW'(bds_pkg::MAX_HEIGHT);
        end
    end

    assign w_even   = {w_eff[bds_pkg::EW-1:1], 1'b0};
    assign h_even   = {h_eff[bds_pkg::HW-1:1], 1'b0};
    assign col_ext  = bds_pkg::EW'(column_count_reg);
    assign row_ext  = bds_pkg::HW'(row_count_reg);
    assign col_plus = col_ext + bds_pkg::EW'(1);
    assign row_plus = row_ext + bds_pkg::HW'(1);

    // ---------------------------------------------------------------------
    // handshake: the middle stage moves on when the result register is free
    // or being emptied, so a beat enters every cycle while out keeps up
    // ---------------------------------------------------------------------
    assign mid_move = mid_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !mid_valid_reg || mid_move;
    assign accept   = in_valid && in_ready;

    // position decode of the accepted pixel
    assign in_block   = (col_ext < w_even) && (row_ext < h_even);
    assign odd_col    = column_count_reg[0];
    assign odd_row    = row_count_reg[0];
    assign line_idx   = column_count_reg[bds_pkg::COL_W-1:1];
    assign line_we    = accept && in_block && odd_col && !odd_row;
    assign produce    = in_block && odd_col && odd_row;
    assign last_pixel = (col_ext == w_even - bds_pkg::EW'(1)) &&
                        (row_ext == h_even - bds_pkg::HW'(1));

    // horizontal pair sum of the held even-column pixel and this one
    assign pair_sum.red   = {1'b0, held_pixel_reg.red_in}   + {1'b0, in_data.red_in};
    assign pair_sum.green = {1'b0, held_pixel_reg.green_in} + {1'b0, in_data.green_in};
    assign pair_sum.blue  = {1'b0, held_pixel_reg.blue_in}  + {1'b0, in_data.blue_in};

    // ---------------------------------------------------------------------
    // line store of pair sums from even rows; odd rows read the same entry
    // ---------------------------------------------------------------------
    bds_ram #(
        .WIDTH (bds_pkg::PAIR_W),
        .DEPTH (bds_pkg::LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_idx),
        .wdata (pair_sum),
        .re    (accept),
        .raddr (line_idx),
        .rdata (line_rdata)
    );

    assign line_rd = line_rdata;

    // ---------------------------------------------------------------------
    // raster counters; a position at or past its limit wraps after the pixel
    // ---------------------------------------------------------------------
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            if (col_plus >= w_eff)
            begin
                column_count_next = '0;
                if (row_plus >= h_eff)
                begin
                    row_count_next = '0;
                end
                else
                begin
                    row_count_next = row_plus[bds_pkg::ROW_W-1:0];
                end
            end
            else
            begin
                column_count_next = col_plus[bds_pkg::COL_W-1:0];
                if (row_ext >= h_eff)
                begin
                    row_count_next = '0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // four-pixel sum and truncating divide by four
    // ---------------------------------------------------------------------
    assign sum_r = {1'b0, line_rd.red}   + {1'b0, mid_pair_reg.red};
    assign sum_g = {1'b0, line_rd.green} + {1'b0, mid_pair_reg.green};
    assign sum_b = {1'b0, line_rd.blue}  + {1'b0, mid_pair_reg.blue};

    assign result.red_out    = sum_r[9:2];
    assign result.green_out  = sum_g[9:2];
    assign result.blue_out   = sum_b[9:2];
    assign result.frame_last = mid_last_reg;

    // valid flags of the two stages
    always_comb
    begin
        mid_valid_next = mid_valid_reg;
        if (accept)
        begin
            mid_valid_next = produce;
        end
        else if (mid_move)
        begin
            mid_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (mid_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            held_pixel_reg   <= '0;
            mid_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            mid_valid_reg    <= mid_valid_next;
            out_valid_reg    <= out_valid_next;
            // even column inside the block: keep it for the pair
            if (accept && in_block && !odd_col)
            begin
                held_pixel_reg <= in_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_pair_reg <= pair_sum;
            mid_last_reg <= last_pixel;
        end
        if (mid_move)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
